/* rtl/btf_pkg.sv */
// btf_pkg: shared types and constants of the branch trace filter.
// Used by the configuration bank, the resolve logic and the top level.
// No dependencies.
package btf_pkg;

    localparam int ADDR_W    = 32;
    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int BAN_CNT_W = 3;
    localparam int BAN_SLOTS = 4;
    localparam int KIND_W    = 2;

    localparam logic [ADDR_W-1:0] INSN_BYTES = ADDR_W'(4);

    // RV32 major opcodes of interest
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;

    // branch funct3 codes
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;
    localparam logic [2:0] F3_JALR = 3'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_START = 3'd0,
        REG_WINDOW_END   = 3'd1,
        REG_FOLLOW_CALLS = 3'd2,
        REG_BANNED_COUNT = 3'd3,
        REG_BAN_A        = 3'd4,
        REG_BAN_B        = 3'd5,
        REG_BAN_C        = 3'd6,
        REG_BAN_D        = 3'd7
    } cfg_reg_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_BRANCH = 2'd0,
        KIND_JUMP   = 2'd1,
        KIND_CALL   = 2'd2,
        KIND_RSVD   = 2'd3
    } kind_t;

    typedef struct packed {
        logic [ADDR_W-1:0]                 window_start;
        logic [ADDR_W-1:0]                 window_end;
        logic                              follow_calls;
        logic [BAN_CNT_W-1:0]              banned_count;
        logic [BAN_SLOTS-1:0][ADDR_W-1:0]  ban_pc;
    } cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] pc;
        logic [31:0]       instr_word;
        logic [31:0]       rs1_value;
        logic [31:0]       rs2_value;
    } insn_t;

    typedef struct packed {
        logic [ADDR_W-1:0] src_addr;
        logic [ADDR_W-1:0] dst_addr;
        logic [ADDR_W-1:0] alt_addr;
        kind_t             kind;
        logic              taken;
        logic              backward;
    } xfer_t;

    // decode status from the resolve logic to the top level
    typedef struct packed {
        logic transfer;   // branch or jump with a defined encoding
        logic call_stop;  // call that is not followed
    } dec_t;

endpackage

/* rtl/btf_in_if.sv */
// btf_in_if: input channel of the branch trace filter, one retired instruction a word.
// Depends on btf_pkg.
interface btf_in_if
    import btf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] pc;
    logic [31:0]       instr_word;
    logic [31:0]       rs1_value;
    logic [31:0]       rs2_value;

    modport source (output valid, output pc, output instr_word, output rs1_value,
                    output rs2_value, input ready);
    modport sink   (input valid, input pc, input instr_word, input rs1_value,
                    input rs2_value, output ready);
endinterface

/* rtl/btf_out_if.sv */
// btf_out_if: output channel of the branch trace filter, one transition a word.
// Depends on btf_pkg.
interface btf_out_if
    import btf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;
    logic [ADDR_W-1:0] alt_addr;
    logic [KIND_W-1:0] kind;
    logic              taken;
    logic              backward;

    modport source (output valid, output src_addr, output dst_addr, output alt_addr,
                    output kind, output taken, output backward, input ready);
    modport sink   (input valid, input src_addr, input dst_addr, input alt_addr,
                    input kind, input taken, input backward, output ready);
endinterface

/* rtl/btf_cfg.sv */
// btf_cfg: configuration register bank of the branch trace filter.
// Depends on btf_pkg.
module btf_cfg
    import btf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WINDOW_START: cfg_next.window_start = cfg_data[ADDR_W-1:0];
                REG_WINDOW_END:   cfg_next.window_end   = cfg_data[ADDR_W-1:0];
                REG_FOLLOW_CALLS: cfg_next.follow_calls = cfg_data[0];
                REG_BANNED_COUNT: cfg_next.banned_count = cfg_data[BAN_CNT_W-1:0];
                default:
                begin
                    // ban slots; an index past the last slot is dropped
                    for (int i = 0; i < BAN_SLOTS; i++)
                    begin
                        if (cfg_index == CFG_IDX_W'(int'(REG_BAN_A) + i))
                            cfg_next.ban_pc[i] = cfg_data[ADDR_W-1:0];
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/btf_resolve.sv */
// btf_resolve: decode of branches and jumps, condition, targets and ban match.
// Pure combinational. Depends on btf_pkg.
module btf_resolve
    import btf_pkg::*;
(
    input  insn_t insn,
    input  cfg_t  cfg,
    output dec_t  dec,
    output xfer_t xfer
);

    logic [6:0]        opc;
    logic [2:0]        f3;
    logic [4:0]        rd;
    logic [31:0]       w;
    logic [ADDR_W-1:0] imm_b, imm_j, imm_i;
    logic [ADDR_W-1:0] br_tgt, nxt_pc, jmp_dst;
    logic              cond, cond_ok, is_br, is_jal, is_jalr, banned;

    assign w      = insn.instr_word;
    assign opc    = w[6:0];
    assign f3     = w[14:12];
    assign rd     = w[11:7];
    assign imm_b  = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    assign imm_j  = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    assign imm_i  = {{20{w[31]}}, w[31:20]};

    assign br_tgt = insn.pc + imm_b;
    assign nxt_pc = insn.pc + INSN_BYTES;

    always_comb
    begin
        cond_ok = 1'b1;
        case (f3)
            F3_BEQ:  cond = (insn.rs1_value == insn.rs2_value);
            F3_BNE:  cond = (insn.rs1_value != insn.rs2_value);
            F3_BLT:  cond = ($signed(insn.rs1_value) < $signed(insn.rs2_value));
            F3_BGE:  cond = ($signed(insn.rs1_value) >= $signed(insn.rs2_value));
            F3_BLTU: cond = (insn.rs1_value < insn.rs2_value);
            F3_BGEU: cond = (insn.rs1_value >= insn.rs2_value);
            default:
            begin
                cond    = 1'b0;
                cond_ok = 1'b0;
            end
        endcase
    end

    assign is_br   = (opc == OPC_BRANCH) && cond_ok;
    assign is_jal  = (opc == OPC_JAL);
    assign is_jalr = (opc == OPC_JALR) && (f3 == F3_JALR);

    // JALR target drops bit 0
    always_comb
    begin
        if (is_jal)
            jmp_dst = insn.pc + imm_j;
        else
            jmp_dst = (insn.rs1_value + imm_i) & ~ADDR_W'(1);
    end

    // counts above the slot count cover every slot
    always_comb
    begin
        banned = 1'b0;
        for (int i = 0; i < BAN_SLOTS; i++)
        begin
            if ((int'(cfg.banned_count) > i) && (cfg.ban_pc[i] == insn.pc))
                banned = 1'b1;
        end
    end

    assign dec.transfer  = is_br || is_jal || is_jalr;
    assign dec.call_stop = (is_jal || is_jalr) && (rd != 5'd0) &&
                           (!cfg.follow_calls || banned);

    always_comb
    begin
        xfer.src_addr = insn.pc;
        if (is_br)
        begin
            xfer.dst_addr = cond ? br_tgt : nxt_pc;
            xfer.alt_addr = cond ? nxt_pc : br_tgt;
            xfer.kind     = KIND_BRANCH;
            xfer.taken    = cond;
            xfer.backward = (xfer.dst_addr < insn.pc);
        end
        else
        begin
            xfer.dst_addr = jmp_dst;
            xfer.alt_addr = '0;
            xfer.kind     = (rd != 5'd0) ? KIND_CALL : KIND_JUMP;
            xfer.taken    = 1'b1;
            xfer.backward = 1'b0;
        end
    end

endmodule

/* rtl/branch_trace_filter.sv */
// branch_trace_filter: RV32 branch trace filter, one retired instruction per word in.
// Pipeline: the input register a_reg, then the output register o_reg that drives trace_out.
// Throughput: one word per cycle; input stalls only while a result waits in a full output reg.
// Reset: all configuration registers 0, monitoring off, restart address 0.
// Depends on btf_pkg, btf_in_if, btf_out_if, btf_cfg, btf_resolve.
module branch_trace_filter
    import btf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    btf_in_if.sink               trace_in,
    btf_out_if.source            trace_out,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    cfg_t  cfg;
    dec_t  dec;
    xfer_t xfer;

    // input stage
    logic  a_valid_reg;
    insn_t a_reg;

    // monitor state
    logic              mon_reg, mon_next;
    logic [ADDR_W-1:0] restart_reg, restart_next;
    logic              mon_eff;
    logic              stop;
    logic              emit;

    // output stage
    logic  o_valid_reg;
    xfer_t o_reg;

    logic  a_move;

    btf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    btf_resolve u_resolve (
        .insn (a_reg),
        .cfg  (cfg),
        .dec  (dec),
        .xfer (xfer)
    );

    // Window check: the start match comes first, the end match wins on a tie.
    always_comb
    begin
        mon_eff = mon_reg;
        if (restart_reg == a_reg.pc)
            mon_eff = 1'b1;
        if ((cfg.window_end - INSN_BYTES) == a_reg.pc)
            mon_eff = 1'b0;
    end

    assign stop = mon_eff && dec.call_stop;
    assign emit = mon_eff && dec.transfer && !dec.call_stop;

    // A word without a result always drains; one with a result waits for
    // room in the output register.
    assign a_move = a_valid_reg && (!emit || !o_valid_reg || trace_out.ready);
    assign trace_in.ready = !a_valid_reg || a_move;

    // State advances once per word, in order, as it leaves the input stage.
    // The user writes config only while idle, so the restart load never races (unenforced).
    always_comb
    begin
        mon_next     = mon_reg;
        restart_next = restart_reg;
        if (a_move)
        begin
            mon_next = mon_eff && !stop;
            if (stop)
                restart_next = a_reg.pc + INSN_BYTES;
        end
        if (cfg_we && (cfg_index == REG_WINDOW_START))
            restart_next = cfg_data[ADDR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            mon_reg     <= 1'b0;
            restart_reg <= '0;
        end
        else
        begin
            mon_reg     <= mon_next;
            restart_reg <= restart_next;
            if (trace_in.ready)
                a_valid_reg <= trace_in.valid;
            if (a_move && emit)
                o_valid_reg <= 1'b1;
            else if (trace_out.ready)
                o_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (trace_in.ready && trace_in.valid)
        begin
            a_reg.pc         <= trace_in.pc;
            a_reg.instr_word <= trace_in.instr_word;
            a_reg.rs1_value  <= trace_in.rs1_value;
            a_reg.rs2_value  <= trace_in.rs2_value;
        end
        if (a_move && emit)
            o_reg <= xfer;
    end

    assign trace_out.valid    = o_valid_reg;
    assign trace_out.src_addr = o_reg.src_addr;
    assign trace_out.dst_addr = o_reg.dst_addr;
    assign trace_out.alt_addr = o_reg.alt_addr;
    assign trace_out.kind     = o_reg.kind;
    assign trace_out.taken    = o_reg.taken;
    assign trace_out.backward = o_reg.backward;

    // unfollowed call always leaves monitoring off
    a_stop_clears_mon: assert property (@(posedge clk) disable iff (!rst_n)
        a_move && stop |=> !mon_reg)
        else $error("monitoring still on after an unfollowed call");

    // a new output word only appears after a word left the input stage
    a_out_from_move: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(o_valid_reg) |-> $past(a_move))
        else $error("output word without a source word");

    // backward flag only on conditional branches
    a_backward_branch: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && o_reg.backward |-> o_reg.kind == KIND_BRANCH)
        else $error("backward flag on a jump");

    // the reserved kind code is never emitted
    a_kind_defined: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg |-> o_reg.kind != KIND_RSVD)
        else $error("reserved kind on output");

endmodule

/* bench/branch_trace_filter_test.sv */
// Self-checking bench for branch_trace_filter: drives retired-instruction words,
// predicts transition words in a scoreboard class and checks them in order.
// Depends on btf_pkg, btf_in_if, btf_out_if and the branch_trace_filter RTL.
`timescale 1ns / 100ps

module branch_trace_filter_test
    import btf_pkg::*;
();

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 6;      // pipeline is two deep, leave margin
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 200;

    // Prediction of the filter: own copy of the registers, the monitoring flag
    // and the restart address, plus the queue of transitions still owed.
    class transition_book;
        cfg_t        cfg;
        logic        monitoring;
        logic [31:0] restart_addr;
        xfer_t       expected_xfers[$];
        int          errors;

        function new();
            cfg          = '0;
            monitoring   = 1'b0;
            restart_addr = '0;
            errors       = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [DATA_W-1:0] v);
            case (idx)
                REG_WINDOW_START:
                begin
                    cfg.window_start = v;
                    restart_addr     = v;
                end
                REG_WINDOW_END:   cfg.window_end   = v;
                REG_FOLLOW_CALLS: cfg.follow_calls = v[0];
                REG_BANNED_COUNT: cfg.banned_count = v[BAN_CNT_W-1:0];
                REG_BAN_A:        cfg.ban_pc[0]    = v;
                REG_BAN_B:        cfg.ban_pc[1]    = v;
                REG_BAN_C:        cfg.ban_pc[2]    = v;
                REG_BAN_D:        cfg.ban_pc[3]    = v;
                default:          ;
            endcase
        endfunction

        // One accepted instruction word: update the window state, then decode.
        function void note_insn(insn_t w);
            logic [6:0]  opc;
            logic [2:0]  f3;
            logic [4:0]  rd;
            logic [31:0] next_pc;
            logic [31:0] target;
            logic        hit;
            logic        ok;
            int          slots;
            xfer_t       x;

            // start check first, end check wins when both match
            if (w.pc == restart_addr)
                monitoring = 1'b1;
            if (cfg.window_end - INSN_BYTES == w.pc)
                monitoring = 1'b0;
            if (!monitoring)
                return;

            opc        = w.instr_word[6:0];
            f3         = w.instr_word[14:12];
            rd         = w.instr_word[11:7];
            next_pc    = w.pc + INSN_BYTES;
            x.src_addr = w.pc;
            x.alt_addr = '0;
            x.taken    = 1'b1;
            x.backward = 1'b0;

            if (opc == OPC_BRANCH)
            begin
                ok = 1'b1;
                case (f3)
                    F3_BEQ:  hit = w.rs1_value == w.rs2_value;
                    F3_BNE:  hit = w.rs1_value != w.rs2_value;
                    F3_BLT:  hit = $signed(w.rs1_value) <  $signed(w.rs2_value);
                    F3_BGE:  hit = $signed(w.rs1_value) >= $signed(w.rs2_value);
                    F3_BLTU: hit = w.rs1_value <  w.rs2_value;
                    F3_BGEU: hit = w.rs1_value >= w.rs2_value;
                    default:
                    begin
                        ok  = 1'b0;
                        hit = 1'b0;
                    end
                endcase
                if (!ok)
                    return;
                target = w.pc + {{19{w.instr_word[31]}}, w.instr_word[31], w.instr_word[7],
                                 w.instr_word[30:25], w.instr_word[11:8], 1'b0};
                x.dst_addr = hit ? target : next_pc;
                x.alt_addr = hit ? next_pc : target;
                x.kind     = KIND_BRANCH;
                x.taken    = hit;
                x.backward = x.dst_addr < w.pc;
            end
            else if (opc == OPC_JAL || (opc == OPC_JALR && f3 == F3_JALR))
            begin
                if (opc == OPC_JAL)
                    x.dst_addr = w.pc + {{11{w.instr_word[31]}}, w.instr_word[31],
                                         w.instr_word[19:12], w.instr_word[20],
                                         w.instr_word[30:21], 1'b0};
                else
                    x.dst_addr = (w.rs1_value + {{20{w.instr_word[31]}}, w.instr_word[31:20]})
                                 & ~32'd1;
                if (rd != 5'd0)
                begin
                    slots = (cfg.banned_count > BAN_SLOTS) ? BAN_SLOTS : int'(cfg.banned_count);
                    hit   = 1'b0;
                    for (int i = 0; i < slots; i++)
                        if (cfg.ban_pc[i] == w.pc)
                            hit = 1'b1;
                    if (!cfg.follow_calls || hit)
                    begin
                        // call not followed: pause and resume at the return address
                        monitoring   = 1'b0;
                        restart_addr = next_pc;
                        return;
                    end
                    x.kind = KIND_CALL;
                end
                else
                    x.kind = KIND_JUMP;
            end
            else
                return;

            expected_xfers = {expected_xfers, x};
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected %h, got %h", name, want, got);
                errors++;
            end
        endfunction

        function void check_xfer(xfer_t got);
            xfer_t want;
            if (expected_xfers.size() == 0)
            begin
                $error("transition word with none expected, src_addr %h", got.src_addr);
                errors++;
                return;
            end
            want = expected_xfers.pop_front();
            compare_field("src_addr", want.src_addr, got.src_addr);
            compare_field("dst_addr", want.dst_addr, got.dst_addr);
            compare_field("alt_addr", want.alt_addr, got.alt_addr);
            compare_field("kind",     32'(want.kind), 32'(got.kind));
            compare_field("taken",    32'(want.taken), 32'(got.taken));
            compare_field("backward", 32'(want.backward), 32'(got.backward));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;
    bit                   no_idle;    // long stretch with the source never idle and the sink always ready
    insn_t                seen_insn;
    xfer_t                seen_xfer;
    transition_book       board;

    btf_in_if  in_bus ();
    btf_out_if out_bus ();

    branch_trace_filter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .trace_in  (in_bus.sink),
        .trace_out (out_bus.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit: far above the slowest legal run (every word stalled on both sides).
    initial
    begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // Result side back-pressure, changed on the falling edge only.
    initial
    begin
        out_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_bus.ready <= rst_n && (no_idle || $urandom_range(99) >= 15);
        end
    end

    // Sample both channels at the rising edge; the scoreboard follows each handshake.
    always @(posedge clk)
    begin
        if (rst_n && in_bus.valid && in_bus.ready)
        begin
            seen_insn.pc         = in_bus.pc;
            seen_insn.instr_word = in_bus.instr_word;
            seen_insn.rs1_value  = in_bus.rs1_value;
            seen_insn.rs2_value  = in_bus.rs2_value;
            board.note_insn(seen_insn);
        end
        if (rst_n && out_bus.valid && out_bus.ready)
        begin
            seen_xfer.src_addr = out_bus.src_addr;
            seen_xfer.dst_addr = out_bus.dst_addr;
            seen_xfer.alt_addr = out_bus.alt_addr;
            seen_xfer.kind     = kind_t'(out_bus.kind);
            seen_xfer.taken    = out_bus.taken;
            seen_xfer.backward = out_bus.backward;
            board.check_xfer(seen_xfer);
        end
    end

    // Encoders for the directed words.
    function automatic logic [31:0] enc_branch(logic [2:0] f3, logic [12:0] off);
        return {off[12], off[10:5], 5'd2, 5'd1, f3, off[4:1], off[11], OPC_BRANCH};
    endfunction

    function automatic logic [31:0] enc_jal(logic [4:0] rd, logic [20:0] off);
        return {off[20], off[10:1], off[11], off[19:12], rd, OPC_JAL};
    endfunction

    function automatic logic [31:0] enc_jalr(logic [4:0] rd, logic [2:0] f3, logic [11:0] imm);
        return {imm, 5'd1, f3, rd, OPC_JALR};
    endfunction

    function automatic cfg_t make_cfg(logic [31:0] start, logic [31:0] stop, logic follow,
                                      logic [2:0] count, logic [31:0] a, logic [31:0] b,
                                      logic [31:0] c, logic [31:0] d);
        cfg_t s;
        s.window_start = start;
        s.window_end   = stop;
        s.follow_calls = follow;
        s.banned_count = count;
        s.ban_pc[0]    = a;
        s.ban_pc[1]    = b;
        s.ban_pc[2]    = c;
        s.ban_pc[3]    = d;
        return s;
    endfunction

    // Random settings with the address extremes and the end-equals-start-plus-four case mixed in.
    function automatic cfg_t draw_settings();
        cfg_t s;
        case ($urandom_range(4))
            0:       s.window_start = 32'h0000_0000;
            1:       s.window_start = 32'hFFFF_FFFC;
            default: s.window_start = $urandom;
        endcase
        case ($urandom_range(5))
            0:       s.window_end = 32'h0000_0000;
            1:       s.window_end = 32'hFFFF_FFFF;
            2:       s.window_end = s.window_start + INSN_BYTES;
            default: s.window_end = $urandom;
        endcase
        s.follow_calls = 1'($urandom_range(1));
        s.banned_count = 3'($urandom_range(7));
        for (int i = 0; i < BAN_SLOTS; i++)
            s.ban_pc[i] = $urandom;
        return s;
    endfunction

    function automatic logic [31:0] random_operand();
        case ($urandom_range(9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Mostly branches and jumps with random fields; the rest other opcodes and noise.
    function automatic logic [31:0] random_word();
        logic [31:0] w;
        logic [2:0]  codes [6];
        int          r;
        codes = '{F3_BEQ, F3_BNE, F3_BLT, F3_BGE, F3_BLTU, F3_BGEU};
        w     = $urandom;
        r     = $urandom_range(99);
        if (r < 45)
        begin
            w[6:0] = OPC_BRANCH;
            if ($urandom_range(9) != 0)
                w[14:12] = codes[$urandom_range(5)];
            else
                w[14:12] = 3'($urandom_range(3, 2));   // undefined branch funct3
        end
        else if (r < 62)
        begin
            w[6:0] = OPC_JAL;
            if ($urandom_range(1) != 0)
                w[11:7] = 5'd0;
        end
        else if (r < 78)
        begin
            w[6:0] = OPC_JALR;
            if ($urandom_range(9) != 0)
                w[14:12] = F3_JALR;
            if ($urandom_range(1) != 0)
                w[11:7] = 5'd0;
        end
        else if (r < 88)
            w[1:0] = 2'b11;                          // any 32-bit opcode
        return w;                                    // else raw, often compressed
    endfunction

    // Present one word and hold it until accepted. Starts and ends at a falling edge;
    // valid stays high on return so back-to-back words need no re-raise.
    task automatic send_insn(insn_t w);
        while (!no_idle && $urandom_range(99) < 15)
        begin
            in_bus.valid <= 1'b0;
            @(negedge clk);
        end
        in_bus.valid      <= 1'b1;
        in_bus.pc         <= w.pc;
        in_bus.instr_word <= w.instr_word;
        in_bus.rs1_value  <= w.rs1_value;
        in_bus.rs2_value  <= w.rs2_value;
        do
            @(posedge clk);
        while (!in_bus.ready);
        @(negedge clk);
    endtask

    task automatic send(logic [31:0] pc, logic [31:0] word, logic [31:0] r1, logic [31:0] r2);
        insn_t w;
        w.pc         = pc;
        w.instr_word = word;
        w.rs1_value  = r1;
        w.rs2_value  = r2;
        send_insn(w);
    endtask

    // Stop sending until every owed transition is out, then let the pipe empty,
    // since a word that makes no result may still be in flight.
    task automatic wait_idle();
        in_bus.valid <= 1'b0;
        while (board.expected_xfers.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Write all eight registers back to back; only called while idle.
    task automatic load_settings(cfg_t s);
        logic [DATA_W-1:0] vals [8];
        vals[REG_WINDOW_START] = s.window_start;
        vals[REG_WINDOW_END]   = s.window_end;
        vals[REG_FOLLOW_CALLS] = DATA_W'(s.follow_calls);
        vals[REG_BANNED_COUNT] = DATA_W'(s.banned_count);
        vals[REG_BAN_A]        = s.ban_pc[0];
        vals[REG_BAN_B]        = s.ban_pc[1];
        vals[REG_BAN_C]        = s.ban_pc[2];
        vals[REG_BAN_D]        = s.ban_pc[3];
        for (int i = 0; i < 8; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            board.set_reg(cfg_reg_t'(i), vals[i]);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Random phase: mostly program-like runs that enter the window at the restart
    // address and walk on; some random pcs, banned call sites and window ends.
    // Words sent while the filter is off and miss the restart address are noise
    // and are not counted.
    task automatic run_phase(int target);
        insn_t       w;
        logic [31:0] last_pc;
        int          done;
        int          r;
        done    = 0;
        last_pc = board.restart_addr;
        while (done < target)
        begin
            r = $urandom_range(99);
            if (board.monitoring)
            begin
                if (r < 60)
                    w.pc = last_pc + INSN_BYTES;
                else if (r < 75)
                    w.pc = $urandom;
                else if (r < 90)
                    w.pc = board.cfg.ban_pc[$urandom_range(BAN_SLOTS - 1)];
                else if (r < 93)
                    w.pc = board.cfg.window_end - INSN_BYTES;
                else
                    w.pc = last_pc + {30'($urandom_range(255)), 2'b00};
            end
            else
                w.pc = (r < 85) ? board.restart_addr : $urandom;
            w.instr_word = random_word();
            w.rs1_value  = random_operand();
            w.rs2_value  = ($urandom_range(3) == 0) ? w.rs1_value : random_operand();
            if (board.monitoring || w.pc == board.restart_addr)
                done++;
            send_insn(w);
            last_pc = w.pc;
            if ($urandom_range(299) == 0)
                wait_idle();
        end
    endtask

    initial
    begin
        board             = new();
        no_idle           = 1'b0;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        in_bus.valid      = 1'b0;
        in_bus.pc         = '0;
        in_bus.instr_word = '0;
        in_bus.rs1_value  = '0;
        in_bus.rs2_value  = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Window 0x1000..0x2000, calls followed, two banned sites (one near the top).
        load_settings(make_cfg(32'h1000, 32'h2000, 1'b1, 3'd2,
                               32'hFFFF_FFF8, 32'h1100, 32'h0, 32'h0));
        send(32'h1000, enc_branch(F3_BEQ, 13'd16), 32'd5, 32'd5);            // window entry
        send(32'h1010, enc_branch(F3_BNE, -13'sd16), 32'd1, 32'd2);          // backward
        send(32'h1014, enc_branch(F3_BLT, 13'd8), 32'h8000_0000, 32'd1);     // signed compare
        send(32'h1018, enc_branch(F3_BGE, 13'h1000), 32'h8000_0000, 32'h7FFF_FFFF);
        send(32'h101C, enc_branch(F3_BLTU, 13'h0FFE), 32'hFFFF_FFFF, 32'd0);
        send(32'h1020, enc_branch(F3_BGEU, 13'd8), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(32'h1024, enc_branch(3'd2, 13'd8), 32'd0, 32'd0);               // undefined funct3
        send(32'h1028, enc_branch(3'd3, 13'd8), 32'd0, 32'd0);
        send(32'h102C, enc_jal(5'd0, 21'h0F_FFFE), 32'd0, 32'd0);            // plain jump
        send(32'h1030, enc_jal(5'd1, 21'h10_0000), 32'd0, 32'd0);            // followed call
        send(32'h1034, enc_jalr(5'd0, F3_JALR, 12'h7FF), 32'd0, 32'd0);      // bit 0 cleared
        send(32'h1038, enc_jalr(5'd0, 3'd1, 12'h0), 32'd0, 32'd0);           // bad JALR funct3
        send(32'h103C, 32'h0000_4501, 32'd0, 32'd0);                         // compressed
        send(32'h1040, 32'h0010_0093, 32'd0, 32'd0);                         // other opcode
        send(32'h1100, enc_jalr(5'd1, F3_JALR, 12'hFFF), 32'hFFFF_FFFF, 32'd0); // banned call
        send(32'h1200, enc_branch(F3_BEQ, 13'd8), 32'd0, 32'd0);             // paused
        send(32'h1104, enc_branch(F3_BEQ, -13'sd4), 32'd0, 32'd0);           // resume
        send(32'hFFFF_FFF8, enc_jal(5'd5, 21'd64), 32'd0, 32'd0);            // banned at top
        send(32'hFFFF_FFFC, enc_branch(F3_BEQ, 13'd8), 32'd3, 32'd3);        // wraps past 0
        send(32'h1FFC, enc_branch(F3_BEQ, 13'd8), 32'd0, 32'd0);             // window end
        wait_idle();

        // Start equals end minus four: the same pc turns it on and off again.
        load_settings(make_cfg(32'hFFFF_FFF0, 32'hFFFF_FFF4, 1'b0, 3'd7,
                               32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send(32'hFFFF_FFF0, enc_branch(F3_BEQ, 13'd8), 32'd0, 32'd0);
        wait_idle();

        // All zero: end check at 0xFFFFFFFC, calls never followed.
        load_settings(make_cfg(32'h0, 32'h0, 1'b0, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0));
        send(32'h0, enc_branch(F3_BNE, 13'h1000), 32'd9, 32'd9);
        send(32'h4, enc_jal(5'd1, 21'd16), 32'd0, 32'd0);
        send(32'h8, enc_jalr(5'd0, F3_JALR, 12'h0), 32'hFFFF_FFFF, 32'd0);
        send(32'hFFFF_FFFC, enc_branch(F3_BEQ, 13'd8), 32'd0, 32'd0);
        wait_idle();

        // Random phases, each with fresh settings; one runs without any idling.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            no_idle = (phase == 3);
            load_settings(draw_settings());
            run_phase(PHASE_ITEMS);
            wait_idle();
        end
        no_idle = 1'b0;

        if (board.expected_xfers.size() != 0)
        begin
            $error("%0d transition words never arrived", board.expected_xfers.size());
            board.errors++;
        end
        if (board.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
